// ----- rtl/drs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and types of the disk request scheduler.
package drs_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
   localparam int CYL_BITS    = 19;
   localparam int TAG_BITS    = 16;
   localparam int AGE_BITS    = 16;
   localparam int DIST_BITS   = CYL_BITS + 1;

   localparam logic [CYL_BITS-1:0] LAST_CYL_RESET = CYL_BITS'(499999);

   // Configuration register indexes
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_LAST = 1'b1;

   typedef enum logic [1:0] {
      MODE_FCFS  = 2'd0,
      MODE_SSTF  = 2'd1,
      MODE_CLOOK = 2'd2,
      MODE_SCAN  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_ENQUEUED   = 2'd0,
      STAT_DISPATCHED = 2'd1,
      STAT_FULL       = 2'd2,
      STAT_EMPTY      = 2'd3
   } status_type;

   // Selection rules tracked side by side during a dispatch sweep
   typedef enum logic [2:0] {
      PICK_OLDEST  = 3'd0,
      PICK_NEAREST = 3'd1,
      PICK_UP      = 3'd2,
      PICK_DOWN    = 3'd3,
      PICK_LOWEST  = 3'd4
   } pick_type;

   localparam int PICK_COUNT = 5;

   typedef struct packed {
      logic [CYL_BITS-1:0] cyl;
      logic [TAG_BITS-1:0] tag;
      logic [AGE_BITS-1:0] age;
   } slot_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] idx;
      logic [CYL_BITS-1:0]  key;
      logic [CYL_BITS-1:0]  cyl;
      logic [TAG_BITS-1:0]  tag;
      logic [AGE_BITS-1:0]  age;
   } best_type;

endpackage

// ----- rtl/disk_request_scheduler_core.sv -----
`timescale 1ns / 1ps
// Disk request scheduler: slot memory, dispatch sweep and result register.
// Enqueue, full and empty: result registered in the cycle after the input beat.
// Dispatch: one slot memory read per cycle over the whole table in ST_SCAN, then
// ST_LAST folds the last read and ST_DECIDE decides. One item at a time; the
// next input beat is taken once the sweep is done and the last result is taken.
// Synchronous reset clears the valid bits, stamp, head and direction and loads
// the default configuration at once; the slot memory needs no clearing pass.
module disk_request_scheduler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [drs_pkg::CYL_BITS-1:0]  req_request_cylinder,
   input  logic [drs_pkg::TAG_BITS-1:0]  req_request_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [drs_pkg::TAG_BITS-1:0]  rsp_chosen_tag,
   output logic [drs_pkg::CYL_BITS-1:0]  rsp_chosen_cylinder,
   output logic [drs_pkg::DIST_BITS-1:0] rsp_travel_distance,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [drs_pkg::CYL_BITS-1:0]  csr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DECIDE
   } state_type;

   state_type                      state_ff;
   logic [drs_pkg::QUEUE_DEPTH-1:0] valid_ff;
   logic [drs_pkg::AGE_BITS-1:0]   stamp_ff;
   logic [drs_pkg::CYL_BITS-1:0]   head_ff;
   logic                           sweep_down_ff;
   logic                           has_disp_ff;
   drs_pkg::mode_type              mode_ff;
   logic [drs_pkg::CYL_BITS-1:0]   last_cyl_ff;
   logic [drs_pkg::SLOT_BITS-1:0]  scan_cnt_ff;
   logic                           rd_pend_ff;
   logic [drs_pkg::SLOT_BITS-1:0]  rd_idx_ff;
   drs_pkg::slot_type              rd_data_ff;
   drs_pkg::best_type              trk_ff [drs_pkg::PICK_COUNT];
   drs_pkg::best_type              trk_in [drs_pkg::PICK_COUNT];

   logic                           rsp_valid_ff;
   drs_pkg::status_type            rsp_status_ff;
   logic [drs_pkg::TAG_BITS-1:0]   rsp_tag_ff;
   logic [drs_pkg::CYL_BITS-1:0]   rsp_cyl_ff;
   logic [drs_pkg::DIST_BITS-1:0]  rsp_dist_ff;

   drs_pkg::slot_type              slot_mem [drs_pkg::QUEUE_DEPTH];

   logic                           req_fire;
   logic                           enq_fire;
   logic                           disp_start;
   logic                           rsp_load;
   logic                           q_full;
   logic                           q_empty;
   logic [drs_pkg::SLOT_BITS-1:0]  free_idx;

   // Decision signals
   drs_pkg::pick_type              sel_pick;
   logic                           rev;
   logic                           new_down;
   drs_pkg::best_type              sel_best;
   logic [drs_pkg::DIST_BITS-1:0]  dist_in;
   logic [drs_pkg::CYL_BITS-1:0]   leg_head;
   logic [drs_pkg::CYL_BITS-1:0]   leg_cyl;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign q_full     = &valid_ff;
   assign q_empty    = ~|valid_ff;
   assign enq_fire   = req_fire && !req_action && !q_full;
   assign disp_start = req_fire && req_action && !q_empty;
   assign rsp_load   = (req_fire && !disp_start) || (state_ff == ST_DECIDE);
   assign csr_ready  = 1'b1;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_tag      = rsp_tag_ff;
   assign rsp_chosen_cylinder = rsp_cyl_ff;
   assign rsp_travel_distance = rsp_dist_ff;

   // Lowest free slot
   always_comb begin
      free_idx = '0;
      for (int i = drs_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = drs_pkg::SLOT_BITS'(i);
         end
      end
   end

   // Fold the entry read last cycle into every tracked pick
   always_comb begin
      logic                          v;
      logic [drs_pkg::AGE_BITS-1:0]  rel;
      logic [drs_pkg::CYL_BITS-1:0]  dif;
      logic                          qual;
      logic [drs_pkg::CYL_BITS-1:0]  key;
      v   = valid_ff[rd_idx_ff];
      rel = stamp_ff - rd_data_ff.age;
      dif = (rd_data_ff.cyl > head_ff) ? rd_data_ff.cyl - head_ff
                                       : head_ff - rd_data_ff.cyl;
      for (int k = 0; k < drs_pkg::PICK_COUNT; k++) begin
         case (drs_pkg::pick_type'(k))
            drs_pkg::PICK_OLDEST: begin
               qual = v;
               key  = '0;
            end
            drs_pkg::PICK_NEAREST: begin
               qual = v;
               key  = dif;
            end
            drs_pkg::PICK_UP: begin
               qual = v && (rd_data_ff.cyl >= head_ff);
               key  = rd_data_ff.cyl;
            end
            drs_pkg::PICK_DOWN: begin
               qual = v && (rd_data_ff.cyl <= head_ff);
               key  = ~rd_data_ff.cyl;
            end
            default: begin
               qual = v;
               key  = rd_data_ff.cyl;
            end
         endcase
         trk_in[k] = trk_ff[k];
         // drop every pick as a sweep begins
         if (disp_start) begin
            trk_in[k].found = 1'b0;
         end
         if (rd_pend_ff && qual &&
             (!trk_ff[k].found || key < trk_ff[k].key ||
              (key == trk_ff[k].key && rel > trk_ff[k].age))) begin
            trk_in[k].found = 1'b1;
            trk_in[k].idx   = rd_idx_ff;
            trk_in[k].key   = key;
            trk_in[k].cyl   = rd_data_ff.cyl;
            trk_in[k].tag   = rd_data_ff.tag;
            trk_in[k].age   = rel;
         end
      end
   end

   // Choose among the tracked picks
   always_comb begin
      drs_pkg::pick_type fwd;
      drs_pkg::pick_type other;
      sel_pick = drs_pkg::PICK_OLDEST;
      rev      = 1'b0;
      new_down = sweep_down_ff;
      fwd      = sweep_down_ff ? drs_pkg::PICK_DOWN : drs_pkg::PICK_UP;
      other    = sweep_down_ff ? drs_pkg::PICK_UP : drs_pkg::PICK_DOWN;
      if (has_disp_ff) begin
         case (mode_ff)
            drs_pkg::MODE_SSTF: begin
               sel_pick = drs_pkg::PICK_NEAREST;
            end
            drs_pkg::MODE_CLOOK: begin
               sel_pick = trk_ff[drs_pkg::PICK_UP].found ? drs_pkg::PICK_UP
                                                         : drs_pkg::PICK_LOWEST;
            end
            drs_pkg::MODE_SCAN: begin
               if (trk_ff[fwd].found) begin
                  sel_pick = fwd;
               end else begin
                  // nothing ahead: turn round
                  rev      = 1'b1;
                  new_down = !sweep_down_ff;
                  sel_pick = trk_ff[other].found ? other : drs_pkg::PICK_OLDEST;
               end
            end
            default: begin
               sel_pick = drs_pkg::PICK_OLDEST;
            end
         endcase
      end
      sel_best = trk_ff[sel_pick];
      leg_head = (head_ff <= last_cyl_ff) ? last_cyl_ff - head_ff : '0;
      leg_cyl  = (sel_best.cyl <= last_cyl_ff) ? last_cyl_ff - sel_best.cyl : '0;
      if (rev && new_down) begin
         dist_in = {1'b0, leg_head} + {1'b0, leg_cyl};
      end else if (rev) begin
         dist_in = {1'b0, head_ff} + {1'b0, sel_best.cyl};
      end else if (sel_best.cyl > head_ff) begin
         dist_in = {1'b0, sel_best.cyl - head_ff};
      end else begin
         dist_in = {1'b0, head_ff - sel_best.cyl};
      end
   end

   // Slot memory: write on enqueue, one registered read per cycle
   always_ff @(posedge clock) begin
      if (enq_fire) begin
         slot_mem[free_idx] <= '{cyl: req_request_cylinder, tag: req_request_tag,
                                 age: stamp_ff};
      end
      rd_data_ff <= slot_mem[scan_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         stamp_ff      <= '0;
         head_ff       <= '0;
         sweep_down_ff <= 1'b0;
         has_disp_ff   <= 1'b0;
         mode_ff       <= drs_pkg::MODE_FCFS;
         last_cyl_ff   <= drs_pkg::LAST_CYL_RESET;
         scan_cnt_ff   <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == drs_pkg::CSR_MODE) begin
               mode_ff <= drs_pkg::mode_type'(csr_data[1:0]);
            end else begin
               last_cyl_ff <= csr_data;
            end
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_pend_ff <= (state_ff == ST_SCAN);
         for (int k = 0; k < drs_pkg::PICK_COUNT; k++) begin
            trk_ff[k] <= trk_in[k];
         end
         case (state_ff)
            ST_IDLE: begin
               scan_cnt_ff <= '0;
               if (req_fire) begin
                  rsp_tag_ff  <= '0;
                  rsp_cyl_ff  <= '0;
                  rsp_dist_ff <= '0;
                  if (!req_action) begin
                     if (q_full) begin
                        rsp_status_ff <= drs_pkg::STAT_FULL;
                     end else begin
                        rsp_status_ff      <= drs_pkg::STAT_ENQUEUED;
                        valid_ff[free_idx] <= 1'b1;
                        stamp_ff           <= stamp_ff + 1'b1;
                     end
                  end else if (q_empty) begin
                     rsp_status_ff <= drs_pkg::STAT_EMPTY;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               rd_idx_ff   <= scan_cnt_ff;
               scan_cnt_ff <= scan_cnt_ff + 1'b1;
               if (scan_cnt_ff == drs_pkg::SLOT_BITS'(drs_pkg::QUEUE_DEPTH - 1)) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               rsp_status_ff          <= drs_pkg::STAT_DISPATCHED;
               rsp_tag_ff             <= sel_best.tag;
               rsp_cyl_ff             <= sel_best.cyl;
               rsp_dist_ff            <= dist_in;
               head_ff                <= sel_best.cyl;
               valid_ff[sel_best.idx] <= 1'b0;
               has_disp_ff            <= 1'b1;
               sweep_down_ff          <= new_down;
               state_ff               <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_enq_result: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_action) |=> rsp_valid)
      else $error("enqueue beat gave no result");

   a_disp_frees_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |=>
         ($countones(valid_ff) + 1 == $countones($past(valid_ff))))
      else $error("dispatch did not free exactly one slot");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      enq_fire |=> (stamp_ff == drs_pkg::AGE_BITS'($past(stamp_ff) + 1'b1)))
      else $error("arrival stamp did not advance on enqueue");

   a_disp_after_decide: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_status_ff == drs_pkg::STAT_DISPATCHED)
         |-> $past(state_ff == ST_DECIDE))
      else $error("dispatched result outside decide step");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action && !q_empty) |=> (state_ff == ST_SCAN && !rsp_valid_ff))
      else $error("dispatch did not start its sweep");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the disk request scheduler core.
module testbench;

   localparam logic [drs_pkg::CYL_BITS-1:0] CYL_MAX = '1;
   localparam logic ACT_ENQUEUE  = 1'b0;
   localparam logic ACT_DISPATCH = 1'b1;

   typedef struct packed {
      drs_pkg::status_type           status;
      logic [drs_pkg::TAG_BITS-1:0]  tag;
      logic [drs_pkg::CYL_BITS-1:0]  cyl;
      logic [drs_pkg::DIST_BITS-1:0] travel;
   } outcome_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_action = ACT_ENQUEUE;
   logic [drs_pkg::CYL_BITS-1:0]  req_request_cylinder = '0;
   logic [drs_pkg::TAG_BITS-1:0]  req_request_tag = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_status;
   logic [drs_pkg::TAG_BITS-1:0]  rsp_chosen_tag;
   logic [drs_pkg::CYL_BITS-1:0]  rsp_chosen_cylinder;
   logic [drs_pkg::DIST_BITS-1:0] rsp_travel_distance;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_index = drs_pkg::CSR_MODE;
   logic [drs_pkg::CYL_BITS-1:0]  csr_data = '0;

   // Predicted scheduler state
   logic                         slot_busy  [drs_pkg::QUEUE_DEPTH];
   logic [drs_pkg::CYL_BITS-1:0] slot_cyl   [drs_pkg::QUEUE_DEPTH];
   logic [drs_pkg::TAG_BITS-1:0] slot_tag   [drs_pkg::QUEUE_DEPTH];
   logic [drs_pkg::AGE_BITS-1:0] slot_stamp [drs_pkg::QUEUE_DEPTH];
   logic [drs_pkg::AGE_BITS-1:0] next_stamp;
   logic [drs_pkg::CYL_BITS-1:0] head_cyl;
   logic                         going_down;
   logic                         dispatched_once;
   drs_pkg::mode_type            sched_mode;
   logic [drs_pkg::CYL_BITS-1:0] far_cyl;

   outcome_type awaited_outcomes[$];
   int          mismatches = 0;
   bit          idling_on = 1'b1;
   int          hold_left = 0;

   disk_request_scheduler_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_request_cylinder (req_request_cylinder),
      .req_request_tag      (req_request_tag),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_chosen_tag       (rsp_chosen_tag),
      .rsp_chosen_cylinder  (rsp_chosen_cylinder),
      .rsp_travel_distance  (rsp_travel_distance),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void clear_predictor();
      for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
         slot_busy[i]  = 1'b0;
         slot_cyl[i]   = '0;
         slot_tag[i]   = '0;
         slot_stamp[i] = '0;
      end
      next_stamp      = '0;
      head_cyl        = '0;
      going_down      = 1'b0;
      dispatched_once = 1'b0;
      sched_mode      = drs_pkg::MODE_FCFS;
      far_cyl         = drs_pkg::LAST_CYL_RESET;
   endfunction

   // Larger is older; the stamp wraps at 16 bits
   function automatic logic [drs_pkg::AGE_BITS-1:0] age_of(int i);
      return next_stamp - slot_stamp[i];
   endfunction

   function automatic logic [drs_pkg::CYL_BITS-1:0] leg_to_far(
         logic [drs_pkg::CYL_BITS-1:0] x);
      return (x <= far_cyl) ? far_cyl - x : '0;
   endfunction

   function automatic int find_slot(drs_pkg::pick_type rule);
      int                           best;
      logic [drs_pkg::CYL_BITS-1:0] best_key;
      logic [drs_pkg::CYL_BITS-1:0] key;
      logic [drs_pkg::CYL_BITS-1:0] c;
      best     = -1;
      best_key = '0;
      for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
         if (!slot_busy[i]) continue;
         c = slot_cyl[i];
         case (rule)
            drs_pkg::PICK_NEAREST: key = (c > head_cyl) ? c - head_cyl : head_cyl - c;
            drs_pkg::PICK_UP: begin
               if (c < head_cyl) continue;
               key = c;
            end
            drs_pkg::PICK_DOWN: begin
               if (c > head_cyl) continue;
               key = CYL_MAX - c;
            end
            drs_pkg::PICK_LOWEST: key = c;
            default: key = '0;
         endcase
         if (best < 0 || key < best_key ||
             (key == best_key && age_of(i) > age_of(best))) begin
            best     = i;
            best_key = key;
         end
      end
      return best;
   endfunction

   function automatic outcome_type scheduler_step(logic action,
                                                  logic [drs_pkg::CYL_BITS-1:0] cyl,
                                                  logic [drs_pkg::TAG_BITS-1:0] tag);
      outcome_type                   res;
      int                            sel;
      logic                          reversed;
      logic [drs_pkg::DIST_BITS-1:0] travel;
      res      = '0;
      sel      = -1;
      reversed = 1'b0;
      travel   = '0;
      if (action == ACT_ENQUEUE) begin
         for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
            if (!slot_busy[i]) begin
               sel = i;
               break;
            end
         end
         if (sel < 0) begin
            res.status = drs_pkg::STAT_FULL;
         end else begin
            slot_busy[sel]  = 1'b1;
            slot_cyl[sel]   = cyl;
            slot_tag[sel]   = tag;
            slot_stamp[sel] = next_stamp;
            next_stamp      = next_stamp + 1'b1;
            res.status      = drs_pkg::STAT_ENQUEUED;
         end
         return res;
      end

      sel = find_slot(drs_pkg::PICK_OLDEST);
      if (sel < 0) begin
         res.status = drs_pkg::STAT_EMPTY;
         return res;
      end

      // The very first dispatch always takes the oldest request
      if (dispatched_once) begin
         case (sched_mode)
            drs_pkg::MODE_SSTF: sel = find_slot(drs_pkg::PICK_NEAREST);
            drs_pkg::MODE_CLOOK: begin
               sel = find_slot(drs_pkg::PICK_UP);
               if (sel < 0) sel = find_slot(drs_pkg::PICK_LOWEST);
            end
            drs_pkg::MODE_SCAN: begin
               sel = find_slot(going_down ? drs_pkg::PICK_DOWN : drs_pkg::PICK_UP);
               if (sel < 0) begin
                  going_down = !going_down;
                  sel = find_slot(going_down ? drs_pkg::PICK_DOWN : drs_pkg::PICK_UP);
                  if (sel < 0) sel = find_slot(drs_pkg::PICK_OLDEST);
                  reversed = 1'b1;
               end
            end
            default: ;
         endcase
      end

      if (reversed && going_down)
         travel = drs_pkg::DIST_BITS'(leg_to_far(head_cyl))
                + drs_pkg::DIST_BITS'(leg_to_far(slot_cyl[sel]));
      else if (reversed)
         travel = drs_pkg::DIST_BITS'(head_cyl) + drs_pkg::DIST_BITS'(slot_cyl[sel]);
      else if (slot_cyl[sel] > head_cyl)
         travel = drs_pkg::DIST_BITS'(slot_cyl[sel] - head_cyl);
      else
         travel = drs_pkg::DIST_BITS'(head_cyl - slot_cyl[sel]);

      res.status = drs_pkg::STAT_DISPATCHED;
      res.tag    = slot_tag[sel];
      res.cyl    = slot_cyl[sel];
      res.travel = travel;

      head_cyl        = slot_cyl[sel];
      slot_busy[sel]  = 1'b0;
      dispatched_once = 1'b1;
      return res;
   endfunction

   // Bias towards values that hit ties, zero seeks and the edge legs
   function automatic logic [drs_pkg::CYL_BITS-1:0] random_cylinder();
      case ($urandom_range(7))
         0: return '0;
         1: return CYL_MAX;
         2: return far_cyl;
         3: return head_cyl;
         4: return drs_pkg::CYL_BITS'(1000 * $urandom_range(1, 4));
         5: return head_cyl + drs_pkg::CYL_BITS'($urandom_range(8))
                   - drs_pkg::CYL_BITS'(4);
         default: return drs_pkg::CYL_BITS'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
   endtask

   task automatic send_item(logic action, logic [drs_pkg::CYL_BITS-1:0] cyl,
                            logic [drs_pkg::TAG_BITS-1:0] tag);
      if (idling_on && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_action           <= action;
      req_request_cylinder <= cyl;
      req_request_tag      <= tag;
      do @(posedge clock); while (!req_ready);
      awaited_outcomes.push_back(scheduler_step(action, cyl, tag));
   endtask

   task automatic drain_outcomes();
      req_valid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both registers back to back; junk in the upper mode bits must be ignored
   task automatic apply_setting(drs_pkg::mode_type m, logic [drs_pkg::CYL_BITS-1:0] last);
      csr_valid <= 1'b1;
      csr_index <= drs_pkg::CSR_MODE;
      csr_data  <= {(drs_pkg::CYL_BITS-2)'($urandom), m};
      do @(posedge clock); while (!csr_ready);
      sched_mode = m;
      csr_index <= drs_pkg::CSR_LAST;
      csr_data  <= last;
      do @(posedge clock); while (!csr_ready);
      far_cyl = last;
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(drs_pkg::mode_type m, logic [drs_pkg::CYL_BITS-1:0] last,
                                   int count, int enqueue_pct);
      drain_outcomes();
      apply_setting(m, last);
      repeat (count)
         send_item(($urandom_range(99) < enqueue_pct) ? ACT_ENQUEUE : ACT_DISPATCH,
                   random_cylinder(), drs_pkg::TAG_BITS'($urandom));
   endtask

   // Reset defaults: empty dispatch, field extremes, first dispatch takes the oldest
   task automatic test_directed_fcfs();
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_ENQUEUE, CYL_MAX, '1);
      send_item(ACT_ENQUEUE, '0, '0);
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(1000), drs_pkg::TAG_BITS'(16'h1234));
      send_item(ACT_DISPATCH, CYL_MAX, '1);
      send_item(ACT_DISPATCH, '0, '0);
   endtask

   // Equal seek either side of the head: the older request must win
   task automatic test_directed_sstf();
      drain_outcomes();
      apply_setting(drs_pkg::MODE_SSTF, drs_pkg::LAST_CYL_RESET);
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(1500), drs_pkg::TAG_BITS'(16'h0011));
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(500), drs_pkg::TAG_BITS'(16'h0022));
      send_item(ACT_DISPATCH, '0, '0);
   endtask

   // Reversal both ways, with a request beyond the edge cylinder
   task automatic test_directed_scan();
      drain_outcomes();
      apply_setting(drs_pkg::MODE_SCAN, drs_pkg::CYL_BITS'(3000));
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(520000), drs_pkg::TAG_BITS'(16'h0033));
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(600), drs_pkg::TAG_BITS'(16'h0044));
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(100), drs_pkg::TAG_BITS'(16'h0055));
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_DISPATCH, '0, '0);
   endtask

   // Nothing at or above the head: wrap to the lowest cylinder
   task automatic test_directed_clook();
      drain_outcomes();
      apply_setting(drs_pkg::MODE_CLOOK, CYL_MAX);
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(700), drs_pkg::TAG_BITS'(16'h0066));
      send_item(ACT_ENQUEUE, drs_pkg::CYL_BITS'(200), drs_pkg::TAG_BITS'(16'h0077));
      send_item(ACT_DISPATCH, '0, '0);
      send_item(ACT_DISPATCH, '0, '0);
   endtask

   task automatic test_random_mix();
      run_random_phase(drs_pkg::MODE_FCFS, CYL_MAX, 90, 55);
      run_random_phase(drs_pkg::MODE_SSTF, '0, 90, 80);
      run_random_phase(drs_pkg::MODE_CLOOK, drs_pkg::CYL_BITS'($urandom), 90, 45);
      run_random_phase(drs_pkg::MODE_SCAN, drs_pkg::LAST_CYL_RESET, 110, 55);
      run_random_phase(drs_pkg::MODE_SCAN, '0, 90, 50);
      run_random_phase(drs_pkg::MODE_SCAN, CYL_MAX, 90, 50);
      run_random_phase(drs_pkg::MODE_SSTF, drs_pkg::CYL_BITS'($urandom), 90, 30);
      run_random_phase(drs_pkg::MODE_SCAN, drs_pkg::CYL_BITS'($urandom_range(4095)), 90, 60);
   endtask

   task automatic test_no_idling();
      idling_on <= 1'b0;
      run_random_phase(drs_pkg::MODE_CLOOK, drs_pkg::CYL_BITS'($urandom), 80, 55);
      drain_outcomes();
      idling_on <= 1'b1;
   endtask

   // Hold the result side off while the sender keeps offering beats
   task automatic test_backpressure();
      drain_outcomes();
      apply_setting(drs_pkg::MODE_SSTF, drs_pkg::CYL_BITS'($urandom));
      hold_left <= 400;
      repeat (20)
         send_item(($urandom_range(99) < 60) ? ACT_ENQUEUE : ACT_DISPATCH,
                   random_cylinder(), drs_pkg::TAG_BITS'($urandom));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready <= !(idling_on && $urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("result with nothing outstanding", '0, 32'(rsp_status));
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            if (rsp_chosen_tag !== want.tag)
               report_mismatch("chosen_tag", 32'(want.tag), 32'(rsp_chosen_tag));
            if (rsp_chosen_cylinder !== want.cyl)
               report_mismatch("chosen_cylinder", 32'(want.cyl), 32'(rsp_chosen_cylinder));
            if (rsp_travel_distance !== want.travel)
               report_mismatch("travel_distance", 32'(want.travel),
                               32'(rsp_travel_distance));
         end
      end
   end

   initial begin
      clear_predictor();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_fcfs();
      test_directed_sstf();
      test_directed_scan();
      test_directed_clook();
      test_random_mix();
      test_no_idling();
      test_backpressure();
      drain_outcomes();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #5000000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
